// ===== rtl/kwm_pkg.sv =====
`timescale 1ns / 1ps
package kwm_pkg;

  // Defaults for the top level parameters
  localparam int DEF_LANES      = 4;
  localparam int DEF_FIFO_DEPTH = 16;

  // Fixed payload widths
  localparam int FUNC_W     = 2;
  localparam int LANE_IN_W  = 2;
  localparam int ID_W       = 32;
  localparam int DENS_W     = 32;
  localparam int STATUS_W   = 2;
  localparam int ENTRY_W    = ID_W + DENS_W;
  // Lane index width inside the block, wide enough for the largest lane count
  localparam int CMD_LANE_W = 3;

  // Input function codes
  typedef enum logic [FUNC_W-1:0] {
    FN_PUSH = 2'd0,
    FN_END  = 2'd1,
    FN_STEP = 2'd2
  } func_t;

  // Result status codes
  typedef enum logic [STATUS_W-1:0] {
    ST_ENTRY = 2'd0,
    ST_WAIT  = 2'd1,
    ST_DONE  = 2'd2,
    ST_OVF   = 2'd3
  } status_t;

  // Sequencer states
  typedef enum logic [2:0] {
    S_IDLE,
    S_SCAN,
    S_DRAIN,
    S_MASK,
    S_EMIT,
    S_RESP
  } state_t;

  // Command from the sequencer to the lane pointer block
  typedef struct packed {
    logic                  push;
    logic                  mark;
    logic                  pop;
    logic [CMD_LANE_W-1:0] lane;
  } lane_cmd_t;

  // Status returned by the lane pointer block
  typedef struct packed {
    logic lane_ok;
    logic lane_full;
    logic any_wait;
  } lane_stat_t;

endpackage

// ===== rtl/kwm_if.sv =====
`timescale 1ns / 1ps

// Input channel: push, end mark or step
interface kwm_in_if import kwm_pkg::*; ();
  logic                 valid;
  logic                 ready;
  logic [FUNC_W-1:0]    func;
  logic [LANE_IN_W-1:0] lane;
  logic [ID_W-1:0]      entity_id;
  logic [DENS_W-1:0]    density_word;

  modport source (output valid, func, lane, entity_id, density_word, input ready);
  modport sink   (input valid, func, lane, entity_id, density_word, output ready);
endinterface

// Result channel
interface kwm_out_if import kwm_pkg::*; ();
  logic                 valid;
  logic                 ready;
  logic [STATUS_W-1:0]  status;
  logic [LANE_IN_W-1:0] out_lane;
  logic [ID_W-1:0]      out_id;
  logic [DENS_W-1:0]    out_density;
  logic                 last;

  modport source (output valid, status, out_lane, out_id, out_density, last, input ready);
  modport sink   (input valid, status, out_lane, out_id, out_density, last, output ready);
endinterface

// ===== rtl/kwm_ram.sv =====
`timescale 1ns / 1ps
// Simple dual-port RAM, one write port, one read port with registered data
module kwm_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    rdata_r <= mem_r[raddr];
  end

  assign rdata = rdata_r;

endmodule

// ===== rtl/kwm_lanes.sv =====
`timescale 1ns / 1ps
// Per-lane read/write pointers, end marks and the address map of the entry store
module kwm_lanes import kwm_pkg::*; #(
  parameter int LANES      = DEF_LANES,
  parameter int FIFO_DEPTH = DEF_FIFO_DEPTH
) (
  input  logic                                  clk,
  input  logic                                  rst_n,
  input  lane_cmd_t                             cmd,
  input  logic [$clog2(LANES)-1:0]              scan_lane,
  output lane_stat_t                            stat,
  output logic [$clog2(LANES)-1:0]              wait_lane,
  output logic [LANES-1:0]                      present,
  output logic [$clog2(LANES*FIFO_DEPTH)-1:0]   wr_addr,
  output logic [$clog2(LANES*FIFO_DEPTH)-1:0]   rd_addr
);

  localparam int LANE_W  = $clog2(LANES);
  localparam int AW      = $clog2(LANES * FIFO_DEPTH);
  localparam int PTR_MOD = 2 * FIFO_DEPTH;
  localparam int PW      = $clog2(PTR_MOD);
  localparam int SW      = $clog2(FIFO_DEPTH);

  logic [PW-1:0]    rp_r [LANES];
  logic [PW-1:0]    wp_r [LANES];
  logic [LANES-1:0] ended_r;

  logic [LANE_W-1:0] ix;
  logic [LANES-1:0]  full_vec;
  logic [PW:0]       fill [LANES];
  logic              lane_ok;
  logic              any_wait;

  // Wrap at twice the depth
  function automatic logic [PW-1:0] ptr_inc(input logic [PW-1:0] p);
    ptr_inc = (p == PW'(PTR_MOD - 1)) ? '0 : p + PW'(1);
  endfunction

  // Entry address: lane base plus pointer modulo the depth
  function automatic logic [AW-1:0] addr_of(input logic [LANE_W-1:0] l,
                                            input logic [PW-1:0]     p);
    logic [SW-1:0] slot;
    slot    = (p >= PW'(FIFO_DEPTH)) ? SW'(p - PW'(FIFO_DEPTH)) : SW'(p);
    addr_of = AW'(AW'(l) * AW'(FIFO_DEPTH)) + AW'(slot);
  endfunction

  assign ix = LANE_W'(cmd.lane);

  // Fill levels and occupancy
  always_comb begin
    for (int l = 0; l < LANES; l++) begin
      fill[l] = {1'b0, wp_r[l]} - {1'b0, rp_r[l]};
      if (wp_r[l] < rp_r[l]) begin
        fill[l] = fill[l] + (PW+1)'(PTR_MOD);
      end
      full_vec[l] = (fill[l] >= (PW+1)'(FIFO_DEPTH));
      present[l]  = (wp_r[l] != rp_r[l]);
    end
  end

  // Lowest lane that is still open and empty
  always_comb begin
    any_wait  = 1'b0;
    wait_lane = '0;
    for (int l = LANES - 1; l >= 0; l--) begin
      if (!ended_r[l] && !present[l]) begin
        any_wait  = 1'b1;
        wait_lane = LANE_W'(l);
      end
    end
  end

  assign lane_ok = (32'(cmd.lane) < LANES);
  assign stat    = '{lane_ok: lane_ok, lane_full: lane_ok && full_vec[ix], any_wait: any_wait};

  assign wr_addr = addr_of(ix, wp_r[ix]);
  assign rd_addr = addr_of(scan_lane, rp_r[scan_lane]);

  // Pointer and end mark updates
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int l = 0; l < LANES; l++) begin
        rp_r[l] <= '0;
        wp_r[l] <= '0;
      end
      ended_r <= '0;
    end else begin
      if (cmd.push && stat.lane_ok && !stat.lane_full) begin
        wp_r[ix] <= ptr_inc(wp_r[ix]);
      end
      if (cmd.mark && stat.lane_ok) begin
        ended_r[ix] <= 1'b1;
      end
      if (cmd.pop) begin
        rp_r[ix] <= ptr_inc(rp_r[ix]);
      end
    end
  end

  // A push reaches here only for a lane in range with room left
  a_push_room: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.push |-> stat.lane_ok && !stat.lane_full)
    else $error("push issued to a full or absent lane");

  // Pops only take entries that are there
  a_pop_present: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.pop |-> stat.lane_ok && present[ix])
    else $error("pop from an empty lane");

  // No lane ever holds more than its depth
  for (genvar g = 0; g < LANES; g++) begin : g_fill_chk
    a_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
      fill[g] <= (PW+1)'(FIFO_DEPTH))
      else $error("lane fill beyond depth");
  end

endmodule

// ===== rtl/kway_merge_group_equal_keys.sv =====
`timescale 1ns / 1ps
// K-way merge of ID-sorted lanes with grouping of equal keys. Entries of all
// lanes live in one single-port-write, registered-read RAM, one FIFO region per
// lane; pointers and end marks sit in flip-flops. A push to a lane with room, or
// an end mark, leaves the block idle. A step that finds an open empty lane, or
// nothing left at all, answers with one result through the response registers
// and the output register. Otherwise the step reads the lane heads from the RAM
// one lane per cycle and then emits the group one entry per cycle whenever the
// output register can take it; the read port of the entry RAM sets the scan
// length. The output register lets the next item be taken while the final
// result still waits. Results for a push to a full lane (status overflow),
// waiting and done carry last high and zero id/density.
module kway_merge_group_equal_keys import kwm_pkg::*; #(
  parameter int LANES      = DEF_LANES,
  parameter int FIFO_DEPTH = DEF_FIFO_DEPTH
) (
  input  logic      clk,
  input  logic      rst_n,
  kwm_in_if.sink    in_if,
  kwm_out_if.source out_if
);

  localparam int LANE_W = $clog2(LANES);
  localparam int AW     = $clog2(LANES * FIFO_DEPTH);

  state_t state_r, state_nxt;

  // Lane block interface
  lane_cmd_t         cmd;
  lane_stat_t        lstat;
  logic [LANE_W-1:0] wait_lane;
  logic [LANES-1:0]  present;
  logic [AW-1:0]     wr_addr;
  logic [AW-1:0]     rd_addr;

  // RAM
  logic               mem_we;
  logic [ENTRY_W-1:0] rd_data;

  // Scan and group bookkeeping
  logic [LANE_W-1:0] scan_r, scan_nxt;
  logic              pend_vld_r;
  logic [LANE_W-1:0] pend_lane_r;
  logic              have_r;
  logic              have_clr;
  logic [ID_W-1:0]   min_r;
  logic [ID_W-1:0]   head_id_r   [LANES];
  logic [DENS_W-1:0] head_dens_r [LANES];
  logic [LANES-1:0]  mask_r, mask_nxt;
  logic [LANE_W-1:0] sel_ix;
  logic [LANES-1:0]  sel_oh;
  logic              sel_last;

  // Pending single-result response
  status_t              resp_status_r, resp_status_nxt;
  logic [LANE_IN_W-1:0] resp_lane_r, resp_lane_nxt;

  // Output register
  logic                 out_valid_r;
  status_t              out_status_r, out_status_nxt;
  logic [LANE_IN_W-1:0] out_lane_r, out_lane_nxt;
  logic [ID_W-1:0]      out_id_r, out_id_nxt;
  logic [DENS_W-1:0]    out_dens_r, out_dens_nxt;
  logic                 out_last_r, out_last_nxt;
  logic                 out_load;
  logic                 out_ok;
  logic                 in_xfer;

  kwm_lanes #(
    .LANES      (LANES),
    .FIFO_DEPTH (FIFO_DEPTH)
  ) u_lanes (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd       (cmd),
    .scan_lane (scan_r),
    .stat      (lstat),
    .wait_lane (wait_lane),
    .present   (present),
    .wr_addr   (wr_addr),
    .rd_addr   (rd_addr)
  );

  kwm_ram #(
    .WIDTH (ENTRY_W),
    .DEPTH (LANES * FIFO_DEPTH)
  ) u_store (
    .clk   (clk),
    .we    (mem_we),
    .waddr (wr_addr),
    .wdata ({in_if.entity_id, in_if.density_word}),
    .raddr (rd_addr),
    .rdata (rd_data)
  );

  assign in_if.ready = (state_r == S_IDLE);
  assign in_xfer     = in_if.valid && in_if.ready;
  assign out_ok      = !out_valid_r || out_if.ready;

  // Lowest lane still to be emitted from the group
  always_comb begin
    sel_ix = '0;
    for (int l = LANES - 1; l >= 0; l--) begin
      if (mask_r[l]) begin
        sel_ix = LANE_W'(l);
      end
    end
    sel_oh   = LANES'(1) << sel_ix;
    sel_last = ((mask_r & ~sel_oh) == '0);
  end

  // Sequencer: next state, lane commands and result loading
  always_comb begin
    state_nxt       = state_r;
    scan_nxt        = scan_r;
    mask_nxt        = mask_r;
    resp_status_nxt = resp_status_r;
    resp_lane_nxt   = resp_lane_r;
    have_clr        = 1'b0;
    mem_we          = 1'b0;
    cmd             = '0;
    cmd.lane        = CMD_LANE_W'(in_if.lane);
    out_load        = 1'b0;
    out_status_nxt  = out_status_r;
    out_lane_nxt    = out_lane_r;
    out_id_nxt      = out_id_r;
    out_dens_nxt    = out_dens_r;
    out_last_nxt    = out_last_r;

    unique case (state_r)
      S_IDLE: begin
        if (in_xfer) begin
          unique case (in_if.func)
            FN_PUSH: begin
              if (lstat.lane_ok) begin
                if (lstat.lane_full) begin
                  resp_status_nxt = ST_OVF;
                  resp_lane_nxt   = in_if.lane;
                  state_nxt       = S_RESP;
                end else begin
                  cmd.push = 1'b1;
                  mem_we   = 1'b1;
                end
              end
            end
            FN_END: begin
              cmd.mark = 1'b1;
            end
            FN_STEP: begin
              if (lstat.any_wait) begin
                resp_status_nxt = ST_WAIT;
                resp_lane_nxt   = LANE_IN_W'(wait_lane);
                state_nxt       = S_RESP;
              end else if (present == '0) begin
                resp_status_nxt = ST_DONE;
                resp_lane_nxt   = '0;
                state_nxt       = S_RESP;
              end else begin
                scan_nxt  = '0;
                have_clr  = 1'b1;
                state_nxt = S_SCAN;
              end
            end
            default: begin
            end
          endcase
        end
      end
      // One head read per lane
      S_SCAN: begin
        if (scan_r == LANE_W'(LANES - 1)) begin
          state_nxt = S_DRAIN;
        end else begin
          scan_nxt = scan_r + LANE_W'(1);
        end
      end
      // Last head lands
      S_DRAIN: begin
        state_nxt = S_MASK;
      end
      // Lanes whose head equals the minimum form the group
      S_MASK: begin
        for (int l = 0; l < LANES; l++) begin
          mask_nxt[l] = present[l] && (head_id_r[l] == min_r);
        end
        state_nxt = S_EMIT;
      end
      S_EMIT: begin
        if (out_ok) begin
          out_load       = 1'b1;
          out_status_nxt = ST_ENTRY;
          out_lane_nxt   = LANE_IN_W'(sel_ix);
          out_id_nxt     = min_r;
          out_dens_nxt   = head_dens_r[sel_ix];
          out_last_nxt   = sel_last;
          cmd.pop        = 1'b1;
          cmd.lane       = CMD_LANE_W'(sel_ix);
          mask_nxt       = mask_r & ~sel_oh;
          if (sel_last) begin
            state_nxt = S_IDLE;
          end
        end
      end
      S_RESP: begin
        if (out_ok) begin
          out_load       = 1'b1;
          out_status_nxt = resp_status_r;
          out_lane_nxt   = resp_lane_r;
          out_id_nxt     = '0;
          out_dens_nxt   = '0;
          out_last_nxt   = 1'b1;
          state_nxt      = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      pend_vld_r  <= 1'b0;
      have_r      <= 1'b0;
      out_valid_r <= 1'b0;
      mask_r      <= '0;
      scan_r      <= '0;
    end else begin
      state_r    <= state_nxt;
      scan_r     <= scan_nxt;
      mask_r     <= mask_nxt;
      pend_vld_r <= (state_r == S_SCAN) && present[scan_r];
      if (have_clr) begin
        have_r <= 1'b0;
      end else if (pend_vld_r) begin
        have_r <= 1'b1;
      end
      if (out_load) begin
        out_valid_r <= 1'b1;
      end else if (out_if.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // Payload registers: head capture, running minimum, responses, output
  always_ff @(posedge clk) begin
    pend_lane_r   <= scan_r;
    resp_status_r <= resp_status_nxt;
    resp_lane_r   <= resp_lane_nxt;
    out_status_r  <= out_status_nxt;
    out_lane_r    <= out_lane_nxt;
    out_id_r      <= out_id_nxt;
    out_dens_r    <= out_dens_nxt;
    out_last_r    <= out_last_nxt;
    if (pend_vld_r) begin
      head_id_r[pend_lane_r]   <= rd_data[ENTRY_W-1:DENS_W];
      head_dens_r[pend_lane_r] <= rd_data[DENS_W-1:0];
      if (!have_r || (rd_data[ENTRY_W-1:DENS_W] < min_r)) begin
        min_r <= rd_data[ENTRY_W-1:DENS_W];
      end
    end
  end

  assign out_if.valid       = out_valid_r;
  assign out_if.status      = out_status_r;
  assign out_if.out_lane    = out_lane_r;
  assign out_if.out_id      = out_id_r;
  assign out_if.out_density = out_dens_r;
  assign out_if.last        = out_last_r;

  // A group always has at least one member while emitting
  a_emit_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_EMIT |-> mask_r != '0)
    else $error("emit state with empty group");

  // At least one head was read before the group is formed
  a_min_found: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_MASK |-> have_r)
    else $error("group formed without a head");

  // The output register is never overwritten before its transfer
  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    out_load |-> !out_valid_r || out_if.ready)
    else $error("result overwritten");

  // Each emitted entry carries the group minimum
  a_emit_min: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_EMIT && out_load) |-> head_id_r[sel_ix] == min_r)
    else $error("emitted id differs from group minimum");

endmodule

// ===== tb/sv/testbench.sv =====
`timescale 1ns / 1ps
module testbench;
  import kwm_pkg::*;

  localparam int NUM_LANES     = DEF_LANES;
  localparam int DEPTH         = DEF_FIFO_DEPTH;
  localparam int HOLD_CYCLES   = 240;
  localparam int SETTLE_CYCLES = 32;
  localparam int CYCLE_LIMIT   = 400000;
  // func code that the block ignores
  localparam logic [FUNC_W-1:0] FN_UNUSED = 2'd3;

  typedef struct packed {
    logic [ID_W-1:0]   id;
    logic [DENS_W-1:0] dens;
  } lane_entry_t;

  typedef struct packed {
    status_t              status;
    logic [LANE_IN_W-1:0] lane;
    logic [ID_W-1:0]      id;
    logic [DENS_W-1:0]    dens;
    logic                 last;
  } group_row_t;

  logic clk = 1'b0;
  logic rst_n;

  kwm_in_if  in_ch ();
  kwm_out_if out_ch ();

  kway_merge_group_equal_keys #(
    .LANES     (NUM_LANES),
    .FIFO_DEPTH(DEPTH)
  ) uut (
    .clk   (clk),
    .rst_n (rst_n),
    .in_if (in_ch),
    .out_if(out_ch)
  );

  // Mirror of the lane FIFOs and end marks
  lane_entry_t lane_mirror[NUM_LANES][$];
  bit          lane_closed[NUM_LANES];
  // Results still owed by the block, oldest first
  group_row_t  rows_due[$];
  group_row_t  want_row;

  int send_idle_pct = 0;
  int recv_idle_pct = 0;
  int hold_asked    = 0;
  int hold_served   = 0;
  int hold_left     = 0;
  int cycle_count   = 0;
  int items_sent    = 0;
  int rows_checked  = 0;
  int mismatches    = 0;
  int n_entries     = 0;
  int n_wait        = 0;
  int n_done        = 0;
  int n_ovf         = 0;

  always #1 clk = ~clk;

  function automatic group_row_t row_of(input status_t st, input logic [LANE_IN_W-1:0] lane,
                                        input logic [ID_W-1:0] id,
                                        input logic [DENS_W-1:0] dens, input logic last);
    group_row_t r;
    r.status = st;
    r.lane   = lane;
    r.id     = id;
    r.dens   = dens;
    r.last   = last;
    return r;
  endfunction

  // Append a result to the tail of the owed list
  function automatic void owe_row(input group_row_t r);
    rows_due.insert(rows_due.size(), r);
  endfunction

  function automatic bit lanes_hold_data();
    bit any;
    any = 1'b0;
    for (int l = 0; l < NUM_LANES; l++)
      if (lane_mirror[l].size() != 0) any = 1'b1;
    return any;
  endfunction

  // Apply one accepted item to the mirror and queue the results it causes
  task automatic merge_apply(input logic [FUNC_W-1:0] func, input logic [LANE_IN_W-1:0] lane,
                             input logic [ID_W-1:0] id, input logic [DENS_W-1:0] dens);
    logic [ID_W-1:0] min_id;
    bit              have_min;
    int              group_len;
    int              k;
    int              l;
    lane_entry_t     ent;
    min_id    = '0;
    have_min  = 1'b0;
    group_len = 0;
    k         = 0;
    case (func)
      FN_PUSH: begin
        if (lane_mirror[lane].size() >= DEPTH) begin
          owe_row(row_of(ST_OVF, lane, '0, '0, 1'b1));
          n_ovf++;
        end else begin
          ent.id   = id;
          ent.dens = dens;
          lane_mirror[lane].insert(lane_mirror[lane].size(), ent);
        end
      end
      FN_END: lane_closed[lane] = 1'b1;
      FN_STEP: begin
        // an open lane with nothing queued holds up the merge
        for (l = 0; l < NUM_LANES; l++) begin
          if (!lane_closed[l] && lane_mirror[l].size() == 0) begin
            owe_row(row_of(ST_WAIT, LANE_IN_W'(l), '0, '0, 1'b1));
            n_wait++;
            return;
          end
        end
        for (l = 0; l < NUM_LANES; l++) begin
          if (lane_mirror[l].size() != 0 && (!have_min || lane_mirror[l][0].id < min_id)) begin
            min_id   = lane_mirror[l][0].id;
            have_min = 1'b1;
          end
        end
        if (!have_min) begin
          owe_row(row_of(ST_DONE, '0, '0, '0, 1'b1));
          n_done++;
          return;
        end
        for (l = 0; l < NUM_LANES; l++)
          if (lane_mirror[l].size() != 0 && lane_mirror[l][0].id == min_id) group_len++;
        // emit the group in lane order, last on the final entry
        for (l = 0; l < NUM_LANES; l++) begin
          if (lane_mirror[l].size() != 0 && lane_mirror[l][0].id == min_id) begin
            k++;
            owe_row(row_of(ST_ENTRY, LANE_IN_W'(l), min_id,
                           lane_mirror[l][0].dens, k == group_len));
            void'(lane_mirror[l].pop_front());
            n_entries++;
          end
        end
      end
      default: ;
    endcase
  endtask

  // One transfer on the input channel; entered and left at a falling edge
  task automatic send_item(input logic [FUNC_W-1:0] func, input logic [LANE_IN_W-1:0] lane,
                           input logic [ID_W-1:0] id, input logic [DENS_W-1:0] dens);
    while ($urandom_range(99) < send_idle_pct) begin
      in_ch.valid <= 1'b0;
      @(negedge clk);
    end
    in_ch.valid        <= 1'b1;
    in_ch.func         <= func;
    in_ch.lane         <= lane;
    in_ch.entity_id    <= id;
    in_ch.density_word <= dens;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    merge_apply(func, lane, id, dens);
    if (func != FN_UNUSED) items_sent++;
    @(negedge clk);
  endtask

  task automatic wait_drained();
    in_ch.valid <= 1'b0;
    while (rows_due.size() != 0) @(negedge clk);
  endtask

  // Stray item: unsorted push, step or ignored code, never an end mark
  task automatic send_noise();
    logic [FUNC_W-1:0] f;
    case ($urandom_range(2))
      0:       f = FN_PUSH;
      1:       f = FN_STEP;
      default: f = FN_UNUSED;
    endcase
    send_item(f, LANE_IN_W'($urandom), $urandom, $urandom);
  endtask

  // Non-decreasing ids per lane from a shared base, so equal keys meet across lanes
  task automatic merge_batch();
    logic [ID_W-1:0] next_id[NUM_LANES];
    int              left[NUM_LANES];
    int              total;
    int              l;
    logic [ID_W-1:0] base;
    base  = $urandom;
    total = 0;
    for (l = 0; l < NUM_LANES; l++) begin
      next_id[l] = base + $urandom_range(2);
      left[l]    = $urandom_range(5);
      total     += left[l];
    end
    while (total > 0) begin
      if ($urandom_range(99) < 8) send_noise();
      l = $urandom_range(NUM_LANES - 1);
      if (left[l] == 0) continue;
      send_item(FN_PUSH, LANE_IN_W'(l), next_id[l], $urandom);
      next_id[l] += $urandom_range(2);
      left[l]--;
      total--;
    end
    repeat ($urandom_range(1, 10)) begin
      if ($urandom_range(99) < 8) send_noise();
      send_item(FN_STEP, LANE_IN_W'($urandom), $urandom, $urandom);
    end
  endtask

  // Field extremes, full groups, partial groups, ignored code, unsorted lane
  task automatic test_directed_merge();
    send_item(FN_STEP, 2'd0, '0, '0);
    send_item(FN_PUSH, 2'd0, 32'h0000_0000, 32'hFFFF_FFFF);
    send_item(FN_PUSH, 2'd1, 32'h0000_0000, 32'h0000_0000);
    send_item(FN_PUSH, 2'd2, 32'h0000_0000, 32'h5555_5555);
    send_item(FN_PUSH, 2'd3, 32'h0000_0000, 32'hAAAA_AAAA);
    send_item(FN_STEP, 2'd3, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    send_item(FN_PUSH, 2'd0, 32'hFFFF_FFFF, 32'h0000_0001);
    send_item(FN_PUSH, 2'd1, 32'h0000_0007, 32'h0000_0002);
    send_item(FN_PUSH, 2'd2, 32'h0000_0007, 32'h0000_0003);
    send_item(FN_PUSH, 2'd3, 32'hFFFF_FFFF, 32'h0000_0004);
    send_item(FN_STEP, 2'd0, '0, '0);
    send_item(FN_UNUSED, 2'd3, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    send_item(FN_STEP, 2'd0, '0, '0);
    send_item(FN_PUSH, 2'd1, 32'hFFFF_FFFF, 32'h8000_0000);
    send_item(FN_PUSH, 2'd2, 32'h0000_0009, 32'h0000_FFFF);
    send_item(FN_PUSH, 2'd2, 32'h0000_0002, 32'hFFFF_0000);
    send_item(FN_STEP, 2'd0, '0, '0);
    send_item(FN_STEP, 2'd0, '0, '0);
    send_item(FN_STEP, 2'd0, '0, '0);
    send_item(FN_PUSH, 2'd2, 32'hFFFF_FFFF, 32'h1234_5678);
    send_item(FN_STEP, 2'd0, '0, '0);
    send_item(FN_STEP, 2'd0, '0, '0);
  endtask

  // Fill one lane past its depth so the extra pushes are flagged
  task automatic test_full_lane();
    int              l;
    int              extra;
    logic [ID_W-1:0] base;
    l     = $urandom_range(NUM_LANES - 1);
    base  = $urandom;
    extra = DEPTH + 3 - lane_mirror[l].size();
    for (int i = 0; i < extra; i++)
      send_item(FN_PUSH, LANE_IN_W'(l), base + i, $urandom);
    send_item(FN_STEP, 2'd0, '0, '0);
  endtask

  task automatic test_random_merge(input int target);
    int start;
    start = items_sent;
    while (items_sent - start < target) merge_batch();
  endtask

  // Long hold on the result side while items keep coming, then a full drain
  task automatic test_result_stall();
    hold_asked++;
    repeat (3) merge_batch();
    wait_drained();
  endtask

  // Close every lane, drain to done, then reopen the merge via ended lanes
  task automatic test_end_of_stream();
    int order[NUM_LANES];
    for (int l = 0; l < NUM_LANES; l++) order[l] = l;
    order.shuffle();
    for (int l = 0; l < NUM_LANES; l++) begin
      send_item(FN_END, LANE_IN_W'(order[l]), $urandom, $urandom);
      if (l == 0) send_item(FN_END, LANE_IN_W'(order[l]), '0, '0);
    end
    while (lanes_hold_data()) send_item(FN_STEP, 2'd0, '0, '0);
    repeat (2) send_item(FN_STEP, LANE_IN_W'($urandom), $urandom, $urandom);
    repeat (6) send_item(FN_PUSH, LANE_IN_W'($urandom), $urandom_range(20), $urandom);
    while (lanes_hold_data()) send_item(FN_STEP, 2'd0, '0, '0);
    send_item(FN_STEP, 2'd0, '0, '0);
  endtask

  task automatic cmp_field(input string fname, input logic [31:0] want, input logic [31:0] got);
    if (got !== want) begin
      mismatches++;
      $display("%0t: %s mismatch, expected %h, got %h", $time, fname, want, got);
    end
  endtask

  // Result side ready, with a counted hold when one is asked for
  always @(negedge clk) begin
    if (hold_served != hold_asked) begin
      hold_left = HOLD_CYCLES;
      hold_served++;
    end
    if (hold_left > 0) begin
      hold_left--;
      out_ch.ready <= 1'b0;
    end else begin
      out_ch.ready <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  // Check every result transfer against the oldest one owed
  always @(posedge clk) begin
    if (rst_n && out_ch.valid && out_ch.ready) begin
      if (rows_due.size() == 0) begin
        mismatches++;
        $display("%0t: unexpected result, status %0d lane %0d id %h density %h last %0d",
                 $time, out_ch.status, out_ch.out_lane, out_ch.out_id, out_ch.out_density,
                 out_ch.last);
      end else begin
        want_row = rows_due.pop_front();
        rows_checked++;
        cmp_field("status", 32'(want_row.status), 32'(out_ch.status));
        cmp_field("out_lane", 32'(want_row.lane), 32'(out_ch.out_lane));
        cmp_field("out_id", want_row.id, out_ch.out_id);
        cmp_field("out_density", want_row.dens, out_ch.out_density);
        cmp_field("last", 32'(want_row.last), 32'(out_ch.last));
      end
    end
  end

  // Watchdog
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("Timeout after %0d cycles, %0d results outstanding", cycle_count, rows_due.size());
      $display("kway_merge_group_equal_keys regression: fail");
      $finish;
    end
  end

  initial begin
    rst_n              = 1'b0;
    in_ch.valid        = 1'b0;
    in_ch.func         = FN_PUSH;
    in_ch.lane         = '0;
    in_ch.entity_id    = '0;
    in_ch.density_word = '0;
    out_ch.ready       = 1'b0;
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    test_directed_merge();

    send_idle_pct = 32;
    recv_idle_pct = 83;
    test_full_lane();
    test_random_merge(70);

    send_idle_pct = 83;
    recv_idle_pct = 32;
    test_result_stall();
    test_random_merge(70);

    send_idle_pct = 0;
    recv_idle_pct = 0;
    test_random_merge(60);
    test_end_of_stream();

    // drain, then let any stray result show up
    wait_drained();
    repeat (SETTLE_CYCLES) @(negedge clk);
    $display("Sent %0d items; checked %0d results: %0d group entries, %0d waiting, %0d done,",
             items_sent, rows_checked, n_entries, n_wait, n_done);
    $display("%0d overflow, over three idle patterns, a long result stall and end of stream",
             n_ovf);
    if (mismatches == 0) begin
      $display("kway_merge_group_equal_keys regression: pass");
    end else begin
      $display("kway_merge_group_equal_keys regression: fail");
    end
    $finish;
  end

endmodule

// ===== kway_merge_group_equal_keys.f =====
rtl/kwm_pkg.sv
rtl/kwm_if.sv
rtl/kwm_ram.sv
rtl/kwm_lanes.sv
rtl/kway_merge_group_equal_keys.sv
tb/sv/testbench.sv
